@@ rtl/core/kbr_pkg.sv @@
// Package for the six-key keyboard report table.
// Holds the event and status codes, the controller states and the cell link types.
// No dependencies.
`timescale 1ns / 1ps

package kbr_pkg;

  localparam logic [2:0] OP_MOD_PRESS   = 3'd0;
  localparam logic [2:0] OP_MOD_RELEASE = 3'd1;
  localparam logic [2:0] OP_KEY_PRESS   = 3'd2;
  localparam logic [2:0] OP_KEY_RELEASE = 3'd3;
  localparam logic [2:0] OP_RELEASE_ALL = 3'd4;

  localparam logic [2:0] STATUS_SENT      = 3'd0;
  localparam logic [2:0] STATUS_HELD      = 3'd1;
  localparam logic [2:0] STATUS_REJECTED  = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

  localparam int REPORT_KEYS = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] code;
    logic       hit;
    logic       free;
  } tok_t;

  typedef struct packed {
    logic       press;
    logic       rel;
    logic       clr_all;
    logic [7:0] code;
  } cmd_t;

endpackage

@@ rtl/core/keyboard_six_key_report_table_top.sv @@
// Sequence: an accepted event passes the EVAL and OUT states for modifier, release-all and
// rejected events, and EVAL, SCAN and OUT for key press or release (the token walks the cells).
// Throughput: one event at a time; the next may enter in the cycle after the result transaction.
// Reset: synchronous active-low rst_n empties all slots, clears the modifier mask and the
// ignored keycode, and returns the controller to idle at once.
`timescale 1ns / 1ps

module keyboard_six_key_report_table_top #(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // code[7:0], link_connected[8], zero[15:9]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // report_modifiers, report_key_0 .. report_key_5
  output logic [3:0]  out_tuser,  // status[2:0], report_sent[3]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // ignored_keycode[7:0]
);

  kbr_pkg::state_t state_r, state_nxt;

  logic [2:0] op_r;
  logic [7:0] code_r;
  logic       link_r;
  logic [7:0] ign_r;
  logic [7:0] mod_r, mod_nxt;
  logic [2:0] status_r, status_nxt;

  kbr_pkg::tok_t tok_w [KEY_SLOTS+1];
  kbr_pkg::cmd_t cmd;
  logic [7:0]    slot_w [KEY_SLOTS];

  logic key_op;
  logic rejected;
  logic scan_done;

  assign key_op   = (op_r == kbr_pkg::OP_KEY_PRESS) || (op_r == kbr_pkg::OP_KEY_RELEASE);
  assign rejected = !link_r
                 || !(op_r inside {kbr_pkg::OP_MOD_PRESS, kbr_pkg::OP_MOD_RELEASE,
                                   kbr_pkg::OP_KEY_PRESS, kbr_pkg::OP_KEY_RELEASE,
                                   kbr_pkg::OP_RELEASE_ALL})
                 || ((op_r != kbr_pkg::OP_RELEASE_ALL) && (code_r == 8'd0))
                 || ((op_r == kbr_pkg::OP_KEY_PRESS) && (code_r == ign_r));
  assign scan_done = tok_w[KEY_SLOTS].vld;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kbr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = kbr_pkg::ST_EVAL;
        end
      end
      kbr_pkg::ST_EVAL: begin
        state_nxt = (!rejected && key_op) ? kbr_pkg::ST_SCAN : kbr_pkg::ST_OUT;
      end
      kbr_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = kbr_pkg::ST_OUT;
        end
      end
      kbr_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = kbr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    tok_w[0]    = '{vld: 1'b0, code: code_r, hit: 1'b0, free: 1'b0};
    cmd         = '{press: 1'b0, rel: 1'b0, clr_all: 1'b0, code: code_r};
    mod_nxt     = mod_r;
    status_nxt  = status_r;
    case (state_r)
      kbr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      kbr_pkg::ST_EVAL: begin
        if (rejected) begin
          status_nxt = kbr_pkg::STATUS_REJECTED;
        end else begin
          status_nxt = kbr_pkg::STATUS_SENT;
          case (op_r)
            kbr_pkg::OP_MOD_PRESS:   mod_nxt = mod_r | code_r;
            kbr_pkg::OP_MOD_RELEASE: mod_nxt = mod_r & ~code_r;
            kbr_pkg::OP_RELEASE_ALL: begin
              mod_nxt     = 8'd0;
              cmd.clr_all = 1'b1;
            end
            default: tok_w[0].vld = 1'b1;
          endcase
        end
      end
      kbr_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (op_r == kbr_pkg::OP_KEY_PRESS) begin
            if (tok_w[KEY_SLOTS].hit) begin
              status_nxt = kbr_pkg::STATUS_HELD;
            end else if (tok_w[KEY_SLOTS].free) begin
              status_nxt = kbr_pkg::STATUS_SENT;
              cmd.press  = 1'b1;
            end else begin
              status_nxt = kbr_pkg::STATUS_FULL;
            end
          end else begin
            if (tok_w[KEY_SLOTS].hit) begin
              status_nxt = kbr_pkg::STATUS_SENT;
              cmd.rel    = 1'b1;
            end else begin
              status_nxt = kbr_pkg::STATUS_NOT_FOUND;
            end
          end
        end
      end
      kbr_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kbr_pkg::ST_IDLE;
      ign_r   <= 8'd0;
      mod_r   <= 8'd0;
    end else begin
      state_r <= state_nxt;
      mod_r   <= mod_nxt;
      if (cfg_valid) begin
        ign_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      code_r <= in_tdata[7:0];
      link_r <= in_tdata[8];
    end
  end

  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
    kbr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok_w[i]),
      .tok_o  (tok_w[i+1]),
      .cmd_i  (cmd),
      .slot_o (slot_w[i])
    );
  end

  assign out_tdata[7:0] = mod_r;
  for (genvar k = 0; k < kbr_pkg::REPORT_KEYS; k++) begin : g_key
    if (k < KEY_SLOTS) begin : g_used
      assign out_tdata[8*k+15:8*k+8] = slot_w[k];
    end else begin : g_empty
      assign out_tdata[8*k+15:8*k+8] = 8'd0;
    end
  end

  assign out_tuser[2:0] = status_r;
  assign out_tuser[3]   = (status_r == kbr_pkg::STATUS_SENT);

endmodule

@@ rtl/core/kbr_cell.sv @@
// One key slot of the report table with its stage of the search token.
// Depends on kbr_pkg for the token and command types.
`timescale 1ns / 1ps

module kbr_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  kbr_pkg::tok_t tok_i,
  output kbr_pkg::tok_t tok_o,
  input  kbr_pkg::cmd_t cmd_i,
  output logic [7:0]    slot_o
);

  logic [7:0]    slot_r, slot_nxt;
  logic          first_r, first_nxt;
  kbr_pkg::tok_t tok_r, tok_nxt;

  always_comb begin
    tok_nxt      = tok_i;
    tok_nxt.hit  = tok_i.hit | (slot_r == tok_i.code);
    tok_nxt.free = tok_i.free | (slot_r == 8'd0);
    first_nxt    = tok_i.vld ? ((slot_r == 8'd0) && !tok_i.free) : first_r;
  end

  always_comb begin
    if (cmd_i.clr_all) begin
      slot_nxt = 8'd0;
    end else if (cmd_i.press && first_r) begin
      slot_nxt = cmd_i.code;
    end else if (cmd_i.rel && (slot_r == cmd_i.code)) begin
      slot_nxt = 8'd0;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= 8'd0;
      tok_r.vld <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

  assign tok_o  = tok_r;
  assign slot_o = slot_r;

endmodule
